@@ hw/rtl/tdpc_pkg.sv @@
`default_nettype none

package tdpc_pkg;

   localparam int SIZE = 20;
   localparam int IN_WIDTH = 20;
   localparam int COLS = (SIZE < IN_WIDTH) ? SIZE : IN_WIDTH;
   localparam int LANE_W = 5;
   localparam int NUM_LANES = (COLS + LANE_W - 1) / LANE_W;
   localparam int PAD_W = NUM_LANES * LANE_W;
   localparam int LANE_IDX_W = $clog2(LANE_W);
   localparam int LANE_CNT_W = $clog2(LANE_W + 1);
   localparam int COL_CNT_W = $clog2(COLS + 1);
   localparam int POS_W = 5;
   localparam int CNT_W = 5;
   localparam int LINES_W = 6;
   localparam int LINES_SUM_W = LINES_W + 1;
   localparam int IMG_W = 16;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_CORRECT = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FIXABLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNFIXABLE = 2'd2;

   localparam logic [CNT_W-1:0] BAD_ROWS_MAX = '1;
   localparam logic [LINES_SUM_W-1:0] LINES_MAX = LINES_SUM_W'((1 << LINES_W) - 1);
   localparam logic [IMG_W-1:0] IMAGE_MAX = '1;

   typedef struct packed {
      logic                  row_par;
      logic                  any_bad;
      logic [LANE_IDX_W-1:0] first_bad;
      logic [LANE_CNT_W-1:0] bad_count;
   } lane_status_type;

   typedef struct packed {
      logic [CNT_W-1:0] bad_rows;
      logic [POS_W-1:0] first_bad_row;
      logic [IMG_W-1:0] image_number;
   } image_info_type;

endpackage

`default_nettype wire

@@ hw/rtl/tdpc_lane.sv @@
`default_nettype none

module tdpc_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [tdpc_pkg::LANE_W-1:0]   seg_bits,
   input  wire logic                          take_row,
   input  wire logic                          take_last,
   output tdpc_pkg::lane_status_type          lane_status
);

   logic [tdpc_pkg::LANE_W-1:0] acc_ff;
   logic [tdpc_pkg::LANE_W-1:0] acc_in;
   logic [tdpc_pkg::LANE_W-1:0] col_bad;

   always_comb begin
      acc_in = acc_ff;
      if (take_last) begin
         acc_in = '0;
      end else if (take_row) begin
         acc_in = acc_ff ^ seg_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // on the column parity item the segment holds the column parity bits
   assign col_bad = acc_ff ^ seg_bits;

   always_comb begin
      lane_status.row_par = ^seg_bits;
      lane_status.any_bad = |col_bad;
      lane_status.first_bad = '0;
      lane_status.bad_count = '0;
      for (int i = tdpc_pkg::LANE_W - 1; i >= 0; i--) begin
         if (col_bad[i]) begin
            lane_status.first_bad = tdpc_pkg::LANE_IDX_W'(i);
         end
      end
      for (int i = 0; i < tdpc_pkg::LANE_W; i++) begin
         lane_status.bad_count = lane_status.bad_count
                                 + tdpc_pkg::LANE_CNT_W'(col_bad[i]);
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tdpc_merge.sv @@
`default_nettype none

module tdpc_merge (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  tdpc_pkg::lane_status_type             lane_status [tdpc_pkg::NUM_LANES],
   input  tdpc_pkg::image_info_type              info,
   input  wire logic                             load,
   input  wire logic                             out_stall,
   output logic                                  out_valid,
   output logic [tdpc_pkg::STATUS_W-1:0]         out_status,
   output logic [tdpc_pkg::POS_W-1:0]            out_error_row,
   output logic [tdpc_pkg::POS_W-1:0]            out_error_col,
   output logic [tdpc_pkg::LINES_W-1:0]          out_bad_lines,
   output logic [tdpc_pkg::IMG_W-1:0]            out_image_number
);

   logic [tdpc_pkg::COL_CNT_W-1:0]   col_count;
   logic [tdpc_pkg::POS_W-1:0]       ecol;
   logic [tdpc_pkg::POS_W-1:0]       erow;
   logic [tdpc_pkg::LINES_SUM_W-1:0] lines_sum;
   logic [tdpc_pkg::LINES_W-1:0]     lines;
   logic [tdpc_pkg::STATUS_W-1:0]    status;

   logic                             valid_ff;
   logic                             valid_in;
   logic [tdpc_pkg::STATUS_W-1:0]    status_ff;
   logic [tdpc_pkg::POS_W-1:0]       erow_ff;
   logic [tdpc_pkg::POS_W-1:0]       ecol_ff;
   logic [tdpc_pkg::LINES_W-1:0]     lines_ff;
   logic [tdpc_pkg::IMG_W-1:0]       image_ff;

   always_comb begin
      col_count = '0;
      ecol = tdpc_pkg::POS_W'(tdpc_pkg::SIZE + 1);
      for (int l = 0; l < tdpc_pkg::NUM_LANES; l++) begin
         col_count = col_count + tdpc_pkg::COL_CNT_W'(lane_status[l].bad_count);
      end
      // lowest lane with a failing column wins
      for (int l = tdpc_pkg::NUM_LANES - 1; l >= 0; l--) begin
         if (lane_status[l].any_bad) begin
            ecol = tdpc_pkg::POS_W'(l * tdpc_pkg::LANE_W)
                   + tdpc_pkg::POS_W'(lane_status[l].first_bad)
                   + tdpc_pkg::POS_W'(1);
         end
      end
   end

   always_comb begin
      erow = (info.first_bad_row != '0) ? info.first_bad_row
                                        : tdpc_pkg::POS_W'(tdpc_pkg::SIZE + 1);
      lines_sum = tdpc_pkg::LINES_SUM_W'(info.bad_rows)
                  + tdpc_pkg::LINES_SUM_W'(col_count);
      if (lines_sum > tdpc_pkg::LINES_MAX) begin
         lines = tdpc_pkg::LINES_W'(tdpc_pkg::LINES_MAX);
      end else begin
         lines = lines_sum[tdpc_pkg::LINES_W-1:0];
      end
      if (info.bad_rows == '0 && col_count == '0) begin
         status = tdpc_pkg::STATUS_CORRECT;
      end else if (info.bad_rows <= tdpc_pkg::CNT_W'(1)
                   && col_count <= tdpc_pkg::COL_CNT_W'(1)) begin
         status = tdpc_pkg::STATUS_FIXABLE;
      end else begin
         status = tdpc_pkg::STATUS_UNFIXABLE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status;
         erow_ff <= erow;
         ecol_ff <= ecol;
         lines_ff <= lines;
         image_ff <= info.image_number;
      end
   end

   assign out_valid = valid_ff;
   assign out_status = status_ff;
   assign out_error_row = erow_ff;
   assign out_error_col = ecol_ff;
   assign out_bad_lines = lines_ff;
   assign out_image_number = image_ff;

endmodule

`default_nettype wire

@@ hw/rtl/two_d_parity_checker.sv @@
// Two-dimensional even parity checker for a square bitmap.
// req channel: one bitmap row per item. The first SIZE items of an image
// carry a data row (req_row_bits, bit j = column j) and its row parity bit;
// the next item carries the column parity row, and its parity bit is unused.
// rsp channel: one result per image, given after the column parity item:
// status, 1-based failing row and column (SIZE+1 when none fails), count of
// failing lines and the image number (starts at 1, wraps 65535 to 1).
// The row is split across four lanes of five columns; each lane keeps its
// column accumulator and checks its columns, and a merge stage combines the
// lanes into the result register.
// Throughput: one item per cycle while req_stall is low. The result is valid
// the cycle after the column parity item is accepted.
// Reset (synchronous) clears the row position, accumulators and bad row
// tracking, sets the image number to 1 and drops rsp_valid.
// When rsp_stall holds a waiting result, req_stall rises only for the next
// column parity item until the result is taken; data rows keep flowing.

`default_nettype none

module two_d_parity_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [tdpc_pkg::IN_WIDTH-1:0]     req_row_bits,
   input  wire logic                              req_parity_bit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tdpc_pkg::STATUS_W-1:0]          rsp_status,
   output logic [tdpc_pkg::POS_W-1:0]             rsp_error_row,
   output logic [tdpc_pkg::POS_W-1:0]             rsp_error_col,
   output logic [tdpc_pkg::LINES_W-1:0]           rsp_bad_lines,
   output logic [tdpc_pkg::IMG_W-1:0]             rsp_image_number
);

   logic [tdpc_pkg::POS_W-1:0]  row_pos_ff;
   logic [tdpc_pkg::POS_W-1:0]  row_pos_in;
   logic [tdpc_pkg::CNT_W-1:0]  bad_rows_ff;
   logic [tdpc_pkg::CNT_W-1:0]  bad_rows_in;
   logic [tdpc_pkg::POS_W-1:0]  first_bad_ff;
   logic [tdpc_pkg::POS_W-1:0]  first_bad_in;
   logic [tdpc_pkg::IMG_W-1:0]  image_ff;
   logic [tdpc_pkg::IMG_W-1:0]  image_in;

   logic                        accept;
   logic                        is_last;
   logic                        take_row;
   logic                        take_last;
   logic                        row_odd;
   logic [tdpc_pkg::PAD_W-1:0]  padded_bits;

   tdpc_pkg::lane_status_type   lane_status [tdpc_pkg::NUM_LANES];
   tdpc_pkg::image_info_type    info;

   assign is_last = (row_pos_ff == tdpc_pkg::POS_W'(tdpc_pkg::SIZE));
   // only the column parity item needs the result register
   assign req_stall = rsp_valid & rsp_stall & is_last;
   assign accept = req_valid & ~req_stall;
   assign take_row = accept & ~is_last;
   assign take_last = accept & is_last;

   // columns beyond SIZE are dropped, missing columns read as zero
   assign padded_bits = tdpc_pkg::PAD_W'(req_row_bits[tdpc_pkg::COLS-1:0]);

   for (genvar l = 0; l < tdpc_pkg::NUM_LANES; l++) begin : g_lane
      tdpc_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .seg_bits    (padded_bits[l*tdpc_pkg::LANE_W +: tdpc_pkg::LANE_W]),
         .take_row    (take_row),
         .take_last   (take_last),
         .lane_status (lane_status[l])
      );
   end

   always_comb begin
      row_odd = req_parity_bit;
      for (int l = 0; l < tdpc_pkg::NUM_LANES; l++) begin
         row_odd = row_odd ^ lane_status[l].row_par;
      end
   end

   always_comb begin
      row_pos_in = row_pos_ff;
      bad_rows_in = bad_rows_ff;
      first_bad_in = first_bad_ff;
      image_in = image_ff;
      if (take_last) begin
         row_pos_in = '0;
         bad_rows_in = '0;
         first_bad_in = '0;
         image_in = (image_ff == tdpc_pkg::IMAGE_MAX) ? tdpc_pkg::IMG_W'(1)
                                                      : image_ff + tdpc_pkg::IMG_W'(1);
      end else if (take_row) begin
         row_pos_in = row_pos_ff + tdpc_pkg::POS_W'(1);
         if (row_odd) begin
            if (first_bad_ff == '0) begin
               first_bad_in = row_pos_ff + tdpc_pkg::POS_W'(1);
            end
            if (bad_rows_ff != tdpc_pkg::BAD_ROWS_MAX) begin
               bad_rows_in = bad_rows_ff + tdpc_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         bad_rows_ff <= '0;
         first_bad_ff <= '0;
         image_ff <= tdpc_pkg::IMG_W'(1);
      end else begin
         row_pos_ff <= row_pos_in;
         bad_rows_ff <= bad_rows_in;
         first_bad_ff <= first_bad_in;
         image_ff <= image_in;
      end
   end

   assign info.bad_rows = bad_rows_ff;
   assign info.first_bad_row = first_bad_ff;
   assign info.image_number = image_ff;

   tdpc_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .lane_status      (lane_status),
      .info             (info),
      .load             (take_last),
      .out_stall        (rsp_stall),
      .out_valid        (rsp_valid),
      .out_status       (rsp_status),
      .out_error_row    (rsp_error_row),
      .out_error_col    (rsp_error_col),
      .out_bad_lines    (rsp_bad_lines),
      .out_image_number (rsp_image_number)
   );

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      row_pos_ff <= tdpc_pkg::POS_W'(tdpc_pkg::SIZE))
      else $error("row position past the column parity row");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take_last |=> rsp_valid && rsp_image_number == $past(image_ff))
      else $error("no result after the column parity item");

   a_image_restart: assert property (@(posedge clock) disable iff (reset)
      take_last |=> row_pos_ff == '0 && bad_rows_ff == '0 && first_bad_ff == '0)
      else $error("per-image state not cleared");

   a_image_nonzero: assert property (@(posedge clock) disable iff (reset)
      image_ff != '0)
      else $error("image number is zero");

   a_first_vs_count: assert property (@(posedge clock) disable iff (reset)
      (first_bad_ff == '0) == (bad_rows_ff == '0))
      else $error("first bad row disagrees with bad row count");
`endif

endmodule

`default_nettype wire
